/* hw/rtl/tcbp_pkg.sv */
// shared types, field widths, command kinds and character codes for the
// text console byte processor; no dependencies
package tcbp_pkg;

   // default screen geometry
   localparam int unsigned SCREEN_WIDTH_DEF  = 80;
   localparam int unsigned SCREEN_HEIGHT_DEF = 25;
   localparam int unsigned TAB_SIZE_DEF      = 8;

   // result port field widths
   localparam int unsigned CHAR_W = 8;
   localparam int unsigned KIND_W = 3;
   localparam int unsigned ROW_W  = 5;
   localparam int unsigned COL_W  = 7;
   localparam int unsigned WORD_W = 16;
   localparam int unsigned POS_W  = 11;

   // at most four commands per byte
   localparam int unsigned MAX_RESULTS = 4;
   localparam int unsigned RES_IDX_W   = 2;
   localparam int unsigned RES_CNT_W   = 3;

   // attribute after reset and after ESC D
   localparam logic [3:0] FG_RESET = 4'd15;
   localparam logic [2:0] BG_RESET = 3'd0;

   // control and character codes
   localparam logic [CHAR_W-1:0] CH_BS         = 8'd8;
   localparam logic [CHAR_W-1:0] CH_TAB        = 8'd9;
   localparam logic [CHAR_W-1:0] CH_LF         = 8'd10;
   localparam logic [CHAR_W-1:0] CH_FF         = 8'd12;
   localparam logic [CHAR_W-1:0] CH_CR         = 8'd13;
   localparam logic [CHAR_W-1:0] CH_ESC        = 8'd27;
   localparam logic [CHAR_W-1:0] CH_SPACE      = 8'd32;
   localparam logic [CHAR_W-1:0] CH_TILDE      = 8'd126;
   localparam logic [CHAR_W-1:0] CH_DEL        = 8'd127;
   localparam logic [CHAR_W-1:0] CH_HIGH_FIRST = 8'd161;
   localparam logic [CHAR_W-1:0] CH_DIGIT_0    = 8'h30;
   localparam logic [CHAR_W-1:0] CH_DIGIT_7    = 8'h37;
   localparam logic [CHAR_W-1:0] CH_DIGIT_8    = 8'h38;
   localparam logic [CHAR_W-1:0] CH_DIGIT_9    = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UPPER_A    = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UPPER_B    = 8'h42;
   localparam logic [CHAR_W-1:0] CH_UPPER_D    = 8'h44;
   localparam logic [CHAR_W-1:0] CH_UPPER_F    = 8'h46;
   localparam logic [CHAR_W-1:0] CH_LOWER_A    = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LOWER_B    = 8'h62;
   localparam logic [CHAR_W-1:0] CH_LOWER_D    = 8'h64;
   localparam logic [CHAR_W-1:0] CH_LOWER_F    = 8'h66;

   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE  = 3'd0,
      KIND_FILL   = 3'd1,
      KIND_SCROLL = 3'd2,
      KIND_CLEAR  = 3'd3,
      KIND_CURSOR = 3'd4
   } kind_type;

   // what the byte after ESC selects
   typedef enum logic [1:0] {
      ESC_NONE = 2'd0,
      ESC_BG   = 2'd1,
      ESC_FG   = 2'd2
   } esc_type;

   typedef struct packed {
      kind_type           kind;
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   col_first;
      logic [COL_W-1:0]   col_last;
      logic [WORD_W-1:0]  cell_word;
      logic [POS_W-1:0]   cursor_pos;
   } cmd_type;

   // commands of one byte, in order, plus how many are meaningful
   typedef struct packed {
      cmd_type [MAX_RESULTS-1:0] cmds;
      logic [RES_CNT_W-1:0]      count;
   } cmd_list_type;

endpackage

/* hw/rtl/text_console_byte_processor_core.sv */
// top level of the text console byte processor: input register, console
// engine and result register; uses tcbp_pkg, tcbp_engine, tcbp_rsp_buf
//
// usage
//   req channel: one byte per beat (req_char_byte, req_end_of_write); the
//     end-of-write flag travels with the byte but does not change anything
//   rsp channel: display commands (cell write, blank span fill, scroll up,
//     clear screen, cursor position), rsp_last high on the final beat a
//     byte causes; bytes taken by the escape parser or ignored give no beat
//   order: a byte accepted at one edge is decoded in the following cycle;
//     its first command is presented in the cycle after it is loaded
//   throughput: one byte per cycle while bytes yield at most one command
//     and rsp_ready stays high; otherwise the next byte waits while the
//     single result port drains the four-entry result register
//   the next byte is decoded while the last command of the previous byte
//     waits, so the input register and the result register overlap
//   reset: cursor at row 0 column 0, white on black, no blink, escape
//     parser idle, no result pending; there is no memory clearing pass
//   stall: with rsp_ready low the pending command holds; a byte with commands
//     waits in the input register, req_ready low; nothing is lost or repeated
module text_console_byte_processor_core #(
   parameter int unsigned SCREEN_WIDTH  = tcbp_pkg::SCREEN_WIDTH_DEF,
   parameter int unsigned SCREEN_HEIGHT = tcbp_pkg::SCREEN_HEIGHT_DEF,
   parameter int unsigned TAB_SIZE      = tcbp_pkg::TAB_SIZE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [tcbp_pkg::CHAR_W-1:0]   req_char_byte,
   input  logic                          req_end_of_write,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tcbp_pkg::KIND_W-1:0]   rsp_kind,
   output logic [tcbp_pkg::ROW_W-1:0]    rsp_row,
   output logic [tcbp_pkg::COL_W-1:0]    rsp_col_first,
   output logic [tcbp_pkg::COL_W-1:0]    rsp_col_last,
   output logic [tcbp_pkg::WORD_W-1:0]   rsp_cell_word,
   output logic [tcbp_pkg::POS_W-1:0]    rsp_cursor_pos,
   output logic                          rsp_last
);
   import tcbp_pkg::*;

   // input register
   logic              in_vld_ff, in_vld_in;
   logic [CHAR_W-1:0] in_char_ff, in_char_in;
   logic              in_eow_ff, in_eow_in;

   cmd_list_type cmd_list;
   cmd_type      rsp_cmd;
   logic         can_load;
   logic         commit;
   logic         load;

   // a byte moves on once its commands fit in the result register; bytes
   // with no commands move on at once
   assign commit    = in_vld_ff && ((cmd_list.count == '0) || can_load);
   assign load      = commit && (cmd_list.count != '0);
   assign req_ready = !in_vld_ff || commit;

   always_comb begin
      in_vld_in  = req_ready ? req_valid : in_vld_ff;
      in_char_in = (req_valid && req_ready) ? req_char_byte : in_char_ff;
      in_eow_in  = (req_valid && req_ready) ? req_end_of_write : in_eow_ff;
   end

   always_ff @(posedge clock) begin
      in_char_ff <= in_char_in;
      in_eow_ff  <= in_eow_in;
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   tcbp_engine #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .TAB_SIZE      (TAB_SIZE)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .char_byte (in_char_ff),
      .commit    (commit),
      .cmd_list  (cmd_list)
   );

   tcbp_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .cmd_list  (cmd_list),
      .can_load  (can_load),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_cmd   (rsp_cmd),
      .rsp_last  (rsp_last)
   );

   // unpack the current command onto the result ports
   assign rsp_kind       = rsp_cmd.kind;
   assign rsp_row        = rsp_cmd.row;
   assign rsp_col_first  = rsp_cmd.col_first;
   assign rsp_col_last   = rsp_cmd.col_last;
   assign rsp_cell_word  = rsp_cmd.cell_word;
   assign rsp_cursor_pos = rsp_cmd.cursor_pos;

   a_held_byte_stable: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !commit) |=> in_vld_ff && $stable(in_char_ff) && $stable(in_eow_ff))
      else $error("waiting byte lost or changed in the input register");

   a_load_shows_beat: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid)
      else $error("loaded commands not presented");

   a_last_is_cursor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> rsp_kind == KIND_CURSOR)
      else $error("final beat of a byte is not a cursor update");

endmodule

/* hw/rtl/tcbp_engine.sv */
// console state (cursor, attribute, escape parser) and the per-byte decode
// that turns one byte into up to four display commands; uses tcbp_pkg
module tcbp_engine #(
   parameter int unsigned SCREEN_WIDTH  = tcbp_pkg::SCREEN_WIDTH_DEF,
   parameter int unsigned SCREEN_HEIGHT = tcbp_pkg::SCREEN_HEIGHT_DEF,
   parameter int unsigned TAB_SIZE      = tcbp_pkg::TAB_SIZE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [tcbp_pkg::CHAR_W-1:0]   char_byte,
   input  logic                          commit,
   output tcbp_pkg::cmd_list_type        cmd_list
);
   import tcbp_pkg::*;

   localparam int unsigned CW     = $clog2(SCREEN_WIDTH);
   localparam int unsigned RW     = $clog2(SCREEN_HEIGHT);
   localparam int unsigned TW     = $clog2(TAB_SIZE + 1);
   localparam int unsigned AW     = ((CW > TW) ? CW : TW) + 1;
   localparam int unsigned PROD_W = RW + CW + 1;
   localparam int unsigned LUT_N  = 2 ** CW;

   localparam logic [AW-1:0] LAST_COL        = AW'(SCREEN_WIDTH - 1);
   localparam logic [AW-1:0] SECOND_LAST_COL = AW'(SCREEN_WIDTH - 2);
   localparam logic [RW-1:0] LAST_ROW        = RW'(SCREEN_HEIGHT - 1);

   // blanks a tab writes from each column
   typedef logic [LUT_N-1:0][TW-1:0] tab_lut_type;

   function automatic tab_lut_type build_tab_lut();
      tab_lut_type lut;
      for (int i = 0; i < LUT_N; i++) begin
         lut[i] = TW'(TAB_SIZE - (i % TAB_SIZE));
      end
      return lut;
   endfunction

   localparam tab_lut_type TAB_LUT = build_tab_lut();

   function automatic cmd_type make_cmd(kind_type k, logic [RW-1:0] r,
                                        logic [AW-1:0] c0, logic [AW-1:0] c1,
                                        logic [WORD_W-1:0] w);
      cmd_type cmd;
      cmd.kind       = k;
      cmd.row        = ROW_W'(r);
      cmd.col_first  = COL_W'(c0);
      cmd.col_last   = COL_W'(c1);
      cmd.cell_word  = w;
      cmd.cursor_pos = '0;
      return cmd;
   endfunction

   function automatic cmd_type make_cursor(logic [RW-1:0] r, logic [AW-1:0] c);
      cmd_type cmd;
      cmd.kind       = KIND_CURSOR;
      cmd.row        = ROW_W'(r);
      cmd.col_first  = COL_W'(c);
      cmd.col_last   = '0;
      cmd.cell_word  = '0;
      cmd.cursor_pos = POS_W'(PROD_W'(r) * PROD_W'(SCREEN_WIDTH) + PROD_W'(c));
      return cmd;
   endfunction

   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [3:0]    fg_ff, fg_in;
   logic [2:0]    bg_ff, bg_in;
   logic          blink_ff, blink_in;
   logic          esc_active_ff, esc_active_in;
   esc_type       esc_target_ff, esc_target_in;

   logic [WORD_W-1:0]    blank_word;
   logic [AW-1:0]        col_cur, col_nx, run_n, first_len, rest, second_len;
   logic [RW-1:0]        row_nx, row_down;
   logic                 at_last_row, run_en, printable;
   logic [RES_CNT_W-1:0] n;
   cmd_type [MAX_RESULTS-1:0] cmds;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff        <= '0;
         col_ff        <= '0;
         fg_ff         <= FG_RESET;
         bg_ff         <= BG_RESET;
         blink_ff      <= 1'b0;
         esc_active_ff <= 1'b0;
         esc_target_ff <= ESC_NONE;
      end else begin
         row_ff        <= row_in;
         col_ff        <= col_in;
         fg_ff         <= fg_in;
         bg_ff         <= bg_in;
         blink_ff      <= blink_in;
         esc_active_ff <= esc_active_in;
         esc_target_ff <= esc_target_in;
      end
   end

   always_comb begin
      blank_word  = {blink_ff, bg_ff, fg_ff, CH_SPACE};
      col_cur     = AW'(col_ff);
      at_last_row = (row_ff >= LAST_ROW);
      row_down    = at_last_row ? row_ff : row_ff + RW'(1);
      printable   = ((char_byte >= CH_SPACE) && (char_byte <= CH_TILDE)) ||
                    (char_byte >= CH_HIGH_FIRST);

      row_nx        = row_ff;
      col_nx        = col_cur;
      fg_in         = fg_ff;
      bg_in         = bg_ff;
      blink_in      = blink_ff;
      esc_active_in = esc_active_ff;
      esc_target_in = esc_target_ff;
      cmds          = '0;
      n             = '0;
      run_en        = 1'b0;
      run_n         = '0;
      first_len     = '0;
      rest          = '0;
      second_len    = '0;

      priority if (esc_active_ff) begin
         esc_active_in = 1'b0;
         esc_target_in = ESC_NONE;
         unique case (esc_target_ff)
            ESC_NONE: begin
               priority if (char_byte == CH_UPPER_B || char_byte == CH_LOWER_B) begin
                  esc_active_in = 1'b1;
                  esc_target_in = ESC_BG;
               end else if (char_byte == CH_UPPER_F || char_byte == CH_LOWER_F) begin
                  esc_active_in = 1'b1;
                  esc_target_in = ESC_FG;
               end else if (char_byte == CH_UPPER_D || char_byte == CH_LOWER_D) begin
                  fg_in    = FG_RESET;
                  bg_in    = BG_RESET;
                  blink_in = 1'b0;
               end else begin
               end
            end
            ESC_BG: begin
               priority if (char_byte >= CH_DIGIT_0 && char_byte <= CH_DIGIT_7) begin
                  bg_in = 3'(char_byte - CH_DIGIT_0);
               end else if (char_byte == CH_DIGIT_8 || char_byte == CH_DIGIT_9) begin
                  bg_in = 3'(char_byte - CH_DIGIT_8);
               end else if (char_byte >= CH_UPPER_A && char_byte <= CH_UPPER_F) begin
                  bg_in = 3'(char_byte - CH_UPPER_A + 8'd2);
               end else if (char_byte >= CH_LOWER_A && char_byte <= CH_LOWER_F) begin
                  bg_in = 3'(char_byte - CH_LOWER_A + 8'd2);
               end else begin
               end
               blink_in = (char_byte > CH_DIGIT_7);
            end
            ESC_FG: begin
               priority if (char_byte >= CH_DIGIT_0 && char_byte <= CH_DIGIT_9) begin
                  fg_in = 4'(char_byte - CH_DIGIT_0);
               end else if (char_byte >= CH_UPPER_A && char_byte <= CH_UPPER_F) begin
                  fg_in = 4'(char_byte - CH_UPPER_A + 8'd10);
               end else begin
               end
            end
            default: begin
            end
         endcase
      end else if (char_byte == CH_BS) begin
         if (col_cur != '0) begin
            col_nx = col_cur - AW'(1);
            cmds[n[RES_IDX_W-1:0]] = make_cursor(row_nx, col_nx);
            n = n + RES_CNT_W'(1);
         end
      end else if (char_byte == CH_TAB) begin
         run_en = 1'b1;
         run_n  = AW'(TAB_LUT[col_ff]);
      end else if (char_byte == CH_LF) begin
         if (col_cur < LAST_COL) begin
            run_en = 1'b1;
            run_n  = LAST_COL - col_cur;
         end
      end else if (char_byte == CH_FF) begin
         cmds[n[RES_IDX_W-1:0]] = make_cmd(KIND_CLEAR, '0, '0, '0, blank_word);
         n = n + RES_CNT_W'(1);
         row_nx = '0;
         col_nx = '0;
         cmds[n[RES_IDX_W-1:0]] = make_cursor(row_nx, col_nx);
         n = n + RES_CNT_W'(1);
      end else if (char_byte == CH_CR) begin
         col_nx = '0;
         cmds[n[RES_IDX_W-1:0]] = make_cursor(row_nx, col_nx);
         n = n + RES_CNT_W'(1);
      end else if (char_byte == CH_ESC) begin
         esc_active_in = 1'b1;
         esc_target_in = ESC_NONE;
      end else if (char_byte == CH_DEL) begin
         if (col_cur == '0) begin
            // back onto the last column of the row above
            if (row_ff != '0) begin
               row_nx = row_ff - RW'(1);
               col_nx = LAST_COL;
               cmds[n[RES_IDX_W-1:0]] = make_cmd(KIND_WRITE, row_nx, col_nx, '0,
                                                 blank_word);
               n = n + RES_CNT_W'(1);
               cmds[n[RES_IDX_W-1:0]] = make_cursor(row_nx, col_nx);
               n = n + RES_CNT_W'(1);
            end
         end else begin
            cmds[n[RES_IDX_W-1:0]] = make_cmd(KIND_WRITE, row_ff, col_cur - AW'(1),
                                              '0, blank_word);
            n = n + RES_CNT_W'(1);
            if (col_cur >= LAST_COL) begin
               // the blank lands on the wrap column: the line wraps
               if (at_last_row) begin
                  cmds[n[RES_IDX_W-1:0]] = make_cmd(KIND_SCROLL, '0, '0, '0,
                                                    blank_word);
                  n = n + RES_CNT_W'(1);
               end
               row_nx = row_down;
               col_nx = '0;
            end else begin
               col_nx = col_cur - AW'(1);
            end
            cmds[n[RES_IDX_W-1:0]] = make_cursor(row_nx, col_nx);
            n = n + RES_CNT_W'(1);
         end
      end else if (printable) begin
         cmds[n[RES_IDX_W-1:0]] = make_cmd(KIND_WRITE, row_ff, col_cur, '0,
                                           {blink_ff, bg_ff, fg_ff, char_byte});
         n = n + RES_CNT_W'(1);
         if (col_cur + AW'(1) >= LAST_COL) begin
            if (at_last_row) begin
               cmds[n[RES_IDX_W-1:0]] = make_cmd(KIND_SCROLL, '0, '0, '0, blank_word);
               n = n + RES_CNT_W'(1);
            end
            row_nx = row_down;
            col_nx = '0;
         end else begin
            col_nx = col_cur + AW'(1);
         end
         cmds[n[RES_IDX_W-1:0]] = make_cursor(row_nx, col_nx);
         n = n + RES_CNT_W'(1);
      end else begin
      end

      // blank run for tab and newline: one span up to the wrap column,
      // then at most one more span on the next row that stops short of it
      if (run_en) begin
         first_len = (col_cur == LAST_COL) ? AW'(1) : (LAST_COL - col_cur);
         if (run_n < first_len) begin
            cmds[n[RES_IDX_W-1:0]] = make_cmd(KIND_FILL, row_ff, col_cur,
                                              col_cur + run_n - AW'(1), blank_word);
            n = n + RES_CNT_W'(1);
            col_nx = col_cur + run_n;
         end else begin
            cmds[n[RES_IDX_W-1:0]] = make_cmd(KIND_FILL, row_ff, col_cur,
                                              col_cur + first_len - AW'(1),
                                              blank_word);
            n = n + RES_CNT_W'(1);
            if (at_last_row) begin
               cmds[n[RES_IDX_W-1:0]] = make_cmd(KIND_SCROLL, '0, '0, '0, blank_word);
               n = n + RES_CNT_W'(1);
            end
            row_nx     = row_down;
            rest       = run_n - first_len;
            second_len = (rest > SECOND_LAST_COL) ? SECOND_LAST_COL : rest;
            if (second_len != '0) begin
               cmds[n[RES_IDX_W-1:0]] = make_cmd(KIND_FILL, row_nx, '0,
                                                 second_len - AW'(1), blank_word);
               n = n + RES_CNT_W'(1);
            end
            col_nx = second_len;
         end
         cmds[n[RES_IDX_W-1:0]] = make_cursor(row_nx, col_nx);
         n = n + RES_CNT_W'(1);
      end

      cmd_list.cmds  = cmds;
      cmd_list.count = n;

      // state moves only when the byte is handed on
      row_in = commit ? row_nx : row_ff;
      col_in = commit ? CW'(col_nx) : col_ff;
      if (!commit) begin
         fg_in         = fg_ff;
         bg_in         = bg_ff;
         blink_in      = blink_ff;
         esc_active_in = esc_active_ff;
         esc_target_in = esc_target_ff;
      end
   end

   a_cursor_on_screen: assert property (@(posedge clock) disable iff (reset)
      (row_ff <= LAST_ROW) && (AW'(col_ff) <= LAST_COL))
      else $error("cursor left the screen");

   a_list_ends_in_cursor: assert property (@(posedge clock) disable iff (reset)
      (commit && cmd_list.count != '0) |->
         cmd_list.cmds[RES_IDX_W'(cmd_list.count - RES_CNT_W'(1))].kind == KIND_CURSOR)
      else $error("command list does not end with a cursor update");

   a_target_needs_escape: assert property (@(posedge clock) disable iff (reset)
      !esc_active_ff |-> esc_target_ff == ESC_NONE)
      else $error("escape target set while parser idle");

endmodule

/* hw/rtl/tcbp_rsp_buf.sv */
// result register: holds the commands of one byte and presents them one
// beat at a time on the result channel; uses tcbp_pkg
module tcbp_rsp_buf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  tcbp_pkg::cmd_list_type  cmd_list,
   output logic                    can_load,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output tcbp_pkg::cmd_type       rsp_cmd,
   output logic                    rsp_last
);
   import tcbp_pkg::*;

   cmd_type [MAX_RESULTS-1:0] cmds_ff, cmds_in;
   logic [RES_IDX_W-1:0]      rd_ff, rd_in;
   logic [RES_CNT_W-1:0]      remain_ff, remain_in;
   logic                      take;

   always_comb begin
      take      = (remain_ff != '0) && rsp_ready;
      can_load  = (remain_ff == '0) || ((remain_ff == RES_CNT_W'(1)) && rsp_ready);
      cmds_in   = load ? cmd_list.cmds : cmds_ff;
      rd_in     = rd_ff;
      remain_in = remain_ff;
      if (load) begin
         rd_in     = '0;
         remain_in = cmd_list.count;
      end else if (take) begin
         rd_in     = rd_ff + RES_IDX_W'(1);
         remain_in = remain_ff - RES_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      cmds_ff <= cmds_in;
      if (reset) begin
         rd_ff     <= '0;
         remain_ff <= '0;
      end else begin
         rd_ff     <= rd_in;
         remain_ff <= remain_in;
      end
   end

   assign rsp_valid = (remain_ff != '0);
   assign rsp_cmd   = cmds_ff[rd_ff];
   assign rsp_last  = (remain_ff == RES_CNT_W'(1));

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> can_load && cmd_list.count != '0 && cmd_list.count <= RES_CNT_W'(MAX_RESULTS))
      else $error("result register loaded while still busy");

endmodule
